### src/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg: shared types and codes of the positional list engine
// Request types, status codes, cell operations and the control group that
// is broadcast along the row of list cells.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int WORD_W   = 32;
  localparam int IDX_W    = 8;   // indexes a list of up to 256 words
  localparam int TYPE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int OUTCNT_W = 5;

  // Request types
  localparam logic [TYPE_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_INS_AFTER = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_RM_FRONT  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_RM_BACK   = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_RM_AT     = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_REPLACE   = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Cell operations
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_INS   = 2'd1;
  localparam logic [1:0] CELL_DEL   = 2'd2;
  localparam logic [1:0] CELL_WRITE = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
  } plc_ctrl_t;

endpackage

### src/plc_cell.sv
// ----------------------------------------------------------------------------
// plc_cell: one slot of the list
// Holds one word and, on a broadcast operation, takes the word of its left
// or right neighbour, the request word, or keeps its own.
// ----------------------------------------------------------------------------
module plc_cell #(
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  plc_pkg::plc_ctrl_t          ctrl,
  input  logic [plc_pkg::WORD_W-1:0]  wdata,
  input  logic [plc_pkg::WORD_W-1:0]  left_word,
  input  logic [plc_pkg::WORD_W-1:0]  right_word,
  output logic [plc_pkg::WORD_W-1:0]  word,
  output logic [plc_pkg::WORD_W-1:0]  taken_word
);
  import plc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                  at_idx;
  logic                  past_idx;
  logic [WORD_W-1:0]     word_next;

  assign at_idx   = (ctrl.idx == MY_IDX);
  assign past_idx = (MY_IDX > ctrl.idx);

  always_comb begin
    word_next = word;
    case (ctrl.op)
      CELL_INS: begin
        if (at_idx) begin
          word_next = wdata;
        end else if (past_idx) begin
          word_next = left_word;
        end
      end
      CELL_DEL: begin
        if (at_idx || past_idx) begin
          word_next = right_word;
        end
      end
      CELL_WRITE: begin
        if (at_idx) begin
          word_next = wdata;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  // Only the cell being removed contributes to the OR of taken words.
  assign taken_word = (ctrl.op == CELL_DEL && at_idx) ? word : '0;

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

### src/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list of signed words
// A row of CAPACITY cells holds the list front first; every request shifts,
// writes or keeps all cells at once and returns a status, word and count.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge at which start is high; busy never
// rises, so one request per cycle is sustained. The result appears on the
// cycle after the request, marked by done for that single cycle, and must be
// captured then. All cells update in parallel, and the next request already
// sees the updated list. Failed requests leave the list unchanged and report
// their status; removed_data is zero unless a removal succeeded.
module positional_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [plc_pkg::TYPE_W-1:0]    req_type,
  input  logic [plc_pkg::IDX_W-1:0]     position,
  input  logic signed [plc_pkg::WORD_W-1:0] data,
  output logic                          done,
  output logic [plc_pkg::STATUS_W-1:0]  status,
  output logic signed [plc_pkg::WORD_W-1:0] removed_data,
  output logic [plc_pkg::OUTCNT_W-1:0]  entry_count
);
  import plc_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [STATUS_W-1:0]    status_next;
  plc_ctrl_t              ctrl;
  logic                   pos_ok;
  logic                   is_full;
  logic                   is_empty;
  logic [IDX_W-1:0]       count_idx;

  logic [WORD_W-1:0]      cell_word  [CAPACITY];
  logic [WORD_W-1:0]      cell_taken [CAPACITY];
  logic [WORD_W-1:0]      taken_any;

  assign busy      = 1'b0;
  assign is_full   = (count == FULL_COUNT);
  assign is_empty  = (count == '0);
  assign pos_ok    = (position != '0) && (9'(position) <= 9'(count));
  // Only used where the count is at most CAPACITY, so it fits the index while CAPACITY is below 256.
  assign count_idx = IDX_W'(count);

  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.idx    = '0;
    status_next = ST_OK;
    count_next  = count;
    if (start) begin
      case (req_type)
        REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AFTER: begin
          if (is_full) begin
            status_next = ST_FULL;
          end else if (req_type == REQ_INS_AFTER && !pos_ok) begin
            status_next = ST_BAD_POS;
          end else begin
            ctrl.op    = CELL_INS;
            count_next = count + 1'b1;
            if (req_type == REQ_INS_BACK) begin
              ctrl.idx = count_idx;
            end else if (req_type == REQ_INS_AFTER) begin
              ctrl.idx = position;
            end
          end
        end
        REQ_RM_FRONT, REQ_RM_BACK, REQ_RM_AT: begin
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else if (req_type == REQ_RM_AT && !pos_ok) begin
            status_next = ST_BAD_POS;
          end else begin
            ctrl.op    = CELL_DEL;
            count_next = count - 1'b1;
            if (req_type == REQ_RM_BACK) begin
              ctrl.idx = count_idx - 1'b1;
            end else if (req_type == REQ_RM_AT) begin
              ctrl.idx = position - 1'b1;
            end
          end
        end
        REQ_REPLACE: begin
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else if (!pos_ok) begin
            status_next = ST_BAD_POS;
          end else begin
            ctrl.op  = CELL_WRITE;
            ctrl.idx = position - 1'b1;
          end
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = data;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    plc_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wdata      (data),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .taken_word (cell_taken[i])
    );
  end

  always_comb begin
    taken_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      taken_any = taken_any | cell_taken[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= start;
    end
  end

  always_ff @(posedge clk) begin
    status       <= status_next;
    removed_data <= taken_any;
    entry_count  <= OUTCNT_W'(count_next);
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (done == $past(start)))
    else $error("done does not follow the request by one cycle");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("list count exceeds capacity");

  a_removed_only_ok: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (removed_data == '0))
    else $error("failed request returned a removed word");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (count == $past(count) || count == $past(count) + 1'b1 ||
                     count == $past(count) - 1'b1))
    else $error("list count moved by more than one");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !start |=> (count == $past(count)))
    else $error("list count changed without a request");

endmodule
